// ===== src/qnl_pkg.sv =====
// Shared constants, widths and types for the quaternion nlerp block.
// Used by qnl_mac, qnl_isqrt and quaternion_nlerp_normalize; depends on nothing.
`default_nettype none
package qnl_pkg;

	localparam int FRAC_BITS = 14;
	localparam int DW        = 16;
	localparam int NC        = 4;
	localparam int CW        = $clog2(NC);
	localparam int WW        = 15;
	localparam int MW        = DW + 1;
	localparam int PW        = 2 * MW;
	localparam int SW        = 2 * DW - 1;
	localparam int LW        = 2 * DW + 1;
	localparam int MAGW      = FRAC_BITS + 1;
	localparam int KW        = $clog2(MAGW);
	localparam int RW        = LW + 2 * FRAC_BITS + 5;

	localparam logic [WW-1:0] ONE_Q   = WW'(1) << FRAC_BITS;
	localparam logic [LW-1:0] LEN_ONE = LW'(1) << (2 * FRAC_BITS);

	typedef logic signed [DW-1:0] comp_t;

	typedef logic [1:0] nstat_t;
	localparam nstat_t NS_UNIT     = 2'd0;
	localparam nstat_t NS_RESCALED = 2'd1;
	localparam nstat_t NS_ZERO     = 2'd2;

	typedef enum logic [2:0] {
		TG_NONE,
		TG_DOT_FIRST,
		TG_DOT,
		TG_BLA,
		TG_BLB,
		TG_SQ
	} tag_kind_t;

	typedef struct packed {
		tag_kind_t       kind;
		logic [CW-1:0]   idx;
	} tag_t;

	typedef struct packed {
		logic            start;
		logic [LW-1:0]   len;
		logic [SW-1:0]   sq;
	} rt_req_t;

	typedef struct packed {
		logic            done;
		logic [MAGW-1:0] mag;
	} rt_sts_t;

endpackage
`default_nettype wire

// ===== src/quaternion_nlerp_normalize.sv =====
// Top level of the quaternion nlerp block: request capture, sequencer and result register.
// Depends on qnl_pkg, qnl_mac and qnl_isqrt.
//
// The block blends two Q1.14 quaternions a and b by an unsigned Q1.14 weight (clamped to one),
// optionally flipping b onto the shorter arc when shortest_path is set and a.b is negative, and
// then normalises the blend exactly: zero length gives zeros with status 2, length exactly one
// passes the blend with status 0, anything else is rescaled to round(c / sqrt(len)) with status 1.
// One request is worked on at a time. The single 17x17 multiplier forms the dot product, the
// blend and the squared length in turn, after which a request whose length is zero or one gives
// its result; otherwise the bit-serial root unit then works on each of the four components in
// turn. A new request can be taken once the result has moved to the output register, even while
// that result is still stalled.
`default_nettype none
module quaternion_nlerp_normalize (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic                   cfg_wdata,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  qnl_pkg::comp_t         a_w,
	input  qnl_pkg::comp_t         a_x,
	input  qnl_pkg::comp_t         a_y,
	input  qnl_pkg::comp_t         a_z,
	input  qnl_pkg::comp_t         b_w,
	input  qnl_pkg::comp_t         b_x,
	input  qnl_pkg::comp_t         b_y,
	input  qnl_pkg::comp_t         b_z,
	input  logic [qnl_pkg::WW-1:0] weight,
	output logic                   out_valid,
	input  logic                   out_stall,
	output qnl_pkg::comp_t         r_w,
	output qnl_pkg::comp_t         r_x,
	output qnl_pkg::comp_t         r_y,
	output qnl_pkg::comp_t         r_z,
	output qnl_pkg::nstat_t        norm_status
);
	import qnl_pkg::*;

	localparam int J_BL     = NC;
	localparam int J_SQ     = J_BL + 2 * NC + 2;
	localparam int MAC_LAST = J_SQ + NC;
	localparam int CNTW     = $clog2(MAC_LAST + 1);
	localparam comp_t MAG_MAX = DW'(ONE_Q);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_MAC    = 6'b000010,
		ST_CHECK  = 6'b000100,
		ST_RSTART = 6'b001000,
		ST_RWAIT  = 6'b010000,
		ST_FINISH = 6'b100000
	} state_t;

	state_t            state_q;
	logic [CNTW-1:0]   cnt_q;
	logic [CW-1:0]     comp_q;
	logic              sp_q;
	logic              out_valid_q;

	comp_t             a_q [NC];
	comp_t             b_q [NC];
	logic [WW-1:0]     t_q;
	comp_t             res_q [NC];
	nstat_t            stat_q;
	comp_t             r_q [NC];
	nstat_t            rstat_q;

	logic              accept;
	logic              load_out;
	logic [WW-1:0]     t_in;
	logic [CNTW-1:0]   jb;
	logic [CNTW-1:0]   js;
	logic [CW-1:0]     sel;
	comp_t             av;
	comp_t             bv;
	comp_t             cv;
	logic signed [MW-1:0] wa;
	logic signed [MW-1:0] wb;
	logic signed [MW-1:0] tw;
	logic signed [MW-1:0] op_a;
	logic signed [MW-1:0] op_b;
	tag_t              tag;
	comp_t             mag16;

	logic signed [PW-1:0] dot;
	comp_t             c [NC];
	logic [SW-1:0]     sq [NC];
	logic [LW-1:0]     len;
	rt_req_t           rt_req;
	rt_sts_t           rt_sts;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign load_out = (state_q == ST_FINISH) && (!out_valid_q || !out_stall);
	assign t_in     = (weight > ONE_Q) ? ONE_Q : weight;

	assign jb = cnt_q - CNTW'(J_BL);
	assign js = cnt_q - CNTW'(J_SQ);

	always_comb begin
		if (state_q != ST_MAC) begin
			sel = comp_q;
		end else if (cnt_q < CNTW'(J_BL)) begin
			sel = cnt_q[CW-1:0];
		end else if (cnt_q < CNTW'(J_BL + 2 * NC)) begin
			sel = jb[CW:1];
		end else begin
			sel = js[CW-1:0];
		end
	end

	assign av = a_q[sel];
	assign bv = b_q[sel];
	assign cv = c[sel];

	assign tw = {2'b00, t_q};
	assign wa = {2'b00, ONE_Q - t_q};
	assign wb = (sp_q && dot[PW-1]) ? -tw : tw;

	always_comb begin
		op_a = '0;
		op_b = '0;
		tag  = '{kind: TG_NONE, idx: sel};
		if (state_q == ST_MAC) begin
			if (cnt_q < CNTW'(J_BL)) begin
				op_a     = {av[DW-1], av};
				op_b     = {bv[DW-1], bv};
				tag.kind = (cnt_q == '0) ? TG_DOT_FIRST : TG_DOT;
			end else if (cnt_q < CNTW'(J_BL + 2 * NC)) begin
				if (!jb[0]) begin
					op_a     = {av[DW-1], av};
					op_b     = wa;
					tag.kind = TG_BLA;
				end else begin
					op_a     = {bv[DW-1], bv};
					op_b     = wb;
					tag.kind = TG_BLB;
				end
			end else if (cnt_q >= CNTW'(J_SQ) && cnt_q < CNTW'(J_SQ + NC)) begin
				op_a     = {cv[DW-1], cv};
				op_b     = {cv[DW-1], cv};
				tag.kind = TG_SQ;
			end
		end
	end

	qnl_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.op_a   (op_a),
		.op_b   (op_b),
		.tag    (tag),
		.dot    (dot),
		.c      (c),
		.sq     (sq),
		.len    (len)
	);

	assign rt_req.start = (state_q == ST_RSTART);
	assign rt_req.len   = len;
	assign rt_req.sq    = sq[comp_q];

	qnl_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rt_req),
		.sts    (rt_sts)
	);

	assign mag16 = DW'(rt_sts.mag);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			comp_q      <= '0;
			sp_q        <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				sp_q <= cfg_wdata;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_MAC;
						cnt_q   <= '0;
					end
				end
				ST_MAC: begin
					if (cnt_q == CNTW'(MAC_LAST)) begin
						state_q <= ST_CHECK;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_CHECK: begin
					if (len == '0 || len == LEN_ONE) begin
						state_q <= ST_FINISH;
					end else begin
						state_q <= ST_RSTART;
						comp_q  <= '0;
					end
				end
				ST_RSTART: state_q <= ST_RWAIT;
				ST_RWAIT: begin
					if (rt_sts.done) begin
						if (comp_q == CW'(NC - 1)) begin
							state_q <= ST_FINISH;
						end else begin
							comp_q  <= comp_q + 1'b1;
							state_q <= ST_RSTART;
						end
					end
				end
				ST_FINISH: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			a_q[0] <= a_w;
			a_q[1] <= a_x;
			a_q[2] <= a_y;
			a_q[3] <= a_z;
			b_q[0] <= b_w;
			b_q[1] <= b_x;
			b_q[2] <= b_y;
			b_q[3] <= b_z;
			t_q    <= t_in;
		end
		if (state_q == ST_CHECK) begin
			if (len == '0) begin
				for (int i = 0; i < NC; i++) begin
					res_q[i] <= '0;
				end
				stat_q <= NS_ZERO;
			end else if (len == LEN_ONE) begin
				for (int i = 0; i < NC; i++) begin
					res_q[i] <= c[i];
				end
				stat_q <= NS_UNIT;
			end else begin
				stat_q <= NS_RESCALED;
			end
		end
		if (state_q == ST_RWAIT && rt_sts.done) begin
			res_q[comp_q] <= cv[DW-1] ? -mag16 : mag16;
		end
		if (load_out) begin
			r_q     <= res_q;
			rstat_q <= stat_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign r_w         = r_q[0];
	assign r_x         = r_q[1];
	assign r_y         = r_q[2];
	assign r_z         = r_q[3];
	assign norm_status = rstat_q;

	a_zero_len_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && norm_status == NS_ZERO |-> r_w == '0 && r_x == '0 && r_y == '0 && r_z == '0)
		else $error("zero-length result carries non-zero components");

	a_rescale_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && norm_status == NS_RESCALED |->
			r_w <= MAG_MAX && r_w >= -MAG_MAX && r_x <= MAG_MAX && r_x >= -MAG_MAX &&
			r_y <= MAG_MAX && r_y >= -MAG_MAX && r_z <= MAG_MAX && r_z >= -MAG_MAX)
		else $error("rescaled component exceeds unit magnitude");

	a_root_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		rt_sts.done |-> state_q == ST_RWAIT)
		else $error("root unit finished outside its wait state");

	a_accept_starts_mac: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q == ST_MAC && cnt_q == '0)
		else $error("accepted request did not start the multiply sequence");

endmodule
`default_nettype wire

// ===== src/qnl_mac.sv =====
// Shared 17x17 signed multiplier with the accumulators for dot product, blend and length.
// Depends on qnl_pkg.
`default_nettype none
module qnl_mac (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic signed [qnl_pkg::MW-1:0] op_a,
	input  logic signed [qnl_pkg::MW-1:0] op_b,
	input  qnl_pkg::tag_t                 tag,
	output logic signed [qnl_pkg::PW-1:0] dot,
	output qnl_pkg::comp_t                c [qnl_pkg::NC],
	output logic [qnl_pkg::SW-1:0]        sq [qnl_pkg::NC],
	output logic [qnl_pkg::LW-1:0]        len
);
	import qnl_pkg::*;

	localparam logic signed [PW-1:0] RND_POS = PW'(2 ** (FRAC_BITS - 1));
	localparam logic signed [PW-1:0] RND_NEG = RND_POS - PW'(1);
	localparam logic signed [PW-1:0] SAT_HI  = PW'(2 ** (DW - 1) - 1);
	localparam logic signed [PW-1:0] SAT_LO  = ~SAT_HI;

	logic signed [PW-1:0] prod_q;
	tag_t                 tag_q;
	logic signed [PW-1:0] acc_q;
	logic signed [PW-1:0] sum_q;
	logic [CW-1:0]        sum_idx_q;
	logic                 rnd_q;
	logic signed [PW-1:0] dot_q;
	comp_t                c_q [NC];
	logic [SW-1:0]        sq_q [NC];
	logic [LW-1:0]        len_q;

	logic signed [PW-1:0] rsum;
	logic signed [PW-1:0] rsh;
	comp_t                c_rnd;

	// Ties round away from zero: a negative sum takes one less before the floor shift.
	always_comb begin
		rsum = sum_q + (sum_q[PW-1] ? RND_NEG : RND_POS);
		rsh  = rsum >>> FRAC_BITS;
		if (rsh > SAT_HI) begin
			c_rnd = SAT_HI[DW-1:0];
		end else if (rsh < SAT_LO) begin
			c_rnd = SAT_LO[DW-1:0];
		end else begin
			c_rnd = rsh[DW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q <= '{kind: TG_NONE, idx: '0};
			rnd_q <= 1'b0;
		end else begin
			tag_q <= tag;
			rnd_q <= (tag_q.kind == TG_BLB);
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;
		case (tag_q.kind)
			TG_DOT_FIRST: dot_q <= prod_q;
			TG_DOT:       dot_q <= dot_q + prod_q;
			TG_BLA:       acc_q <= prod_q;
			TG_BLB: begin
				sum_q     <= acc_q + prod_q;
				sum_idx_q <= tag_q.idx;
			end
			TG_SQ: begin
				sq_q[tag_q.idx] <= prod_q[SW-1:0];
				len_q <= ((tag_q.idx == '0) ? '0 : len_q) + LW'(prod_q[SW-1:0]);
			end
			default: ;
		endcase
		if (rnd_q) begin
			c_q[sum_idx_q] <= c_rnd;
		end
	end

	assign dot = dot_q;
	assign c   = c_q;
	assign sq  = sq_q;
	assign len = len_q;

endmodule
`default_nettype wire

// ===== src/qnl_isqrt.sv =====
// Bit-serial unit that forms round(|c| * 2^FRAC_BITS / sqrt(len)) one result bit per cycle
// with a single add and compare. Depends on qnl_pkg.
`default_nettype none
module qnl_isqrt (
	input  logic               clk,
	input  logic               arst_n,
	input  qnl_pkg::rt_req_t   req,
	output qnl_pkg::rt_sts_t   sts
);
	import qnl_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [KW-1:0]     k_q;
	logic signed [RW-1:0] p_q;
	logic signed [RW-1:0] a_q;
	logic signed [RW-1:0] b_q;
	logic signed [RW-1:0] kk_q;
	logic [MAGW-1:0]   m_q;

	logic signed [RW-1:0] trial;
	logic                 ok;

	// With o = 2m-1, p holds o*o*len, a holds o*len scaled for the current bit and b holds len
	// scaled for the square of that bit, so a trial bit costs one three-input add.
	assign trial = p_q + a_q + b_q;
	assign ok    = !m_q[FRAC_BITS] && (trial <= kk_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			k_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				k_q    <= KW'(FRAC_BITS);
			end else if (busy_q) begin
				if (k_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					k_q <= k_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			p_q  <= RW'(req.len);
			a_q  <= -(RW'(req.len) << (FRAC_BITS + 2));
			b_q  <= RW'(req.len) << (2 * FRAC_BITS + 2);
			kk_q <= RW'(req.sq) << (2 * FRAC_BITS + 2);
			m_q  <= '0;
		end else if (busy_q) begin
			if (ok) begin
				p_q      <= trial;
				m_q[k_q] <= 1'b1;
				a_q      <= (a_q >>> 1) + b_q;
			end else begin
				a_q      <= a_q >>> 1;
			end
			b_q <= b_q >>> 2;
		end
	end

	assign sts.done = done_q;
	assign sts.mag  = m_q;

endmodule
`default_nettype wire
